// ----- rtl/periodic_grid_smoothing_core_defines.svh -----
// Assertion macros for the periodic grid smoothing checker
`ifndef PERIODIC_GRID_SMOOTHING_CORE_DEFINES_SVH
`define PERIODIC_GRID_SMOOTHING_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgs checker: same-cycle property failed");

// next-cycle implication, off during reset
`define PGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgs checker: next-cycle property failed");

// next-cycle implication, checked during reset too
`define PGS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pgs checker: reset property failed");

`endif

// ----- rtl/pgs_pkg.sv -----
// Package: shared types, constants and helpers of the grid smoothing block
`default_nettype none
package pgs_pkg;
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int DATA_W    = 32;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CRD_W     = CFG_W;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = DATA_W + 4;
  localparam int DIV_SHIFT = 4;
  localparam int CTR_SHIFT = 3;
  localparam int TAP_W     = 4;

  localparam logic [DATA_W-1:0] BIAS = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic FUNC_WR = 1'b0;
  localparam logic FUNC_RD = 1'b1;

  localparam logic [CFG_W-1:0] RST_ROWS = 7'd64;
  localparam logic [CFG_W-1:0] RST_COLS = 7'd64;

  localparam logic [TAP_W-1:0] TAP_CTR = 4'd0;
  localparam logic [TAP_W-1:0] TAP_UP  = 4'd1;
  localparam logic [TAP_W-1:0] TAP_DN  = 4'd2;
  localparam logic [TAP_W-1:0] TAP_LF  = 4'd3;
  localparam logic [TAP_W-1:0] TAP_RT  = 4'd4;
  localparam logic [TAP_W-1:0] TAP_UL  = 4'd5;
  localparam logic [TAP_W-1:0] TAP_DL  = 4'd6;
  localparam logic [TAP_W-1:0] TAP_UR  = 4'd7;
  localparam logic [TAP_W-1:0] TAP_DR  = 4'd8;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_DR;

  typedef struct packed {
    logic                     func;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] sample;
  } pgs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] smoothed;
    logic                     addr_error;
  } pgs_out_t;

  typedef struct packed {
    logic             take;
    logic             nbr;
    logic             wr;
    logic             rd;
    logic [TAP_W-1:0] tap;
    logic             clr;
    logic             load;
  } pgs_cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_range;
    logic out_free;
  } pgs_sts_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int unsigned maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      res = CFG_W'(maxv);
    end
    return res;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/pgs_ram.sv -----
// Generic single-port RAM with registered read
`default_nettype none
module pgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/pgs_ctrl.sv -----
// Controller: sequences write, range check, nine cell fetches and result load
`default_nettype none
module pgs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pgs_pkg::pgs_sts_t sts,
  output pgs_pkg::pgs_cmd_t      cmd
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEC   = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [pgs_pkg::TAP_W-1:0] tap_r, tap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= pgs_pkg::TAP_CTR;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!sts.is_read) begin
          cmd.wr    = sts.in_range;
          state_nxt = ST_IDLE;
        end else if (!sts.in_range) begin
          state_nxt = ST_RES;
        end else begin
          cmd.nbr   = 1'b1;
          cmd.clr   = 1'b1;
          tap_nxt   = pgs_pkg::TAP_CTR;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.rd  = 1'b1;
        tap_nxt = tap_r + pgs_pkg::TAP_W'(1);
        if (tap_r == pgs_pkg::TAP_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/pgs_dp.sv -----
// Datapath: item and size registers, neighbor rows and columns, grid memory,
// accumulator and output register
`default_nettype none
module pgs_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pgs_pkg::pgs_in_t                in_data,
  input  wire logic                            cfg_we,
  input  wire logic [pgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pgs_pkg::CFG_W-1:0]       cfg_data,
  input  wire pgs_pkg::pgs_cmd_t               cmd,
  output pgs_pkg::pgs_sts_t                    sts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output pgs_pkg::pgs_out_t                    out_data
);
  pgs_pkg::pgs_in_t              item_r;
  logic [pgs_pkg::CFG_W-1:0]     nr_r, nc_r;
  logic [pgs_pkg::CRD_W-1:0]     up_r, dn_r, lf_r, rt_r;
  logic [pgs_pkg::CRD_W-1:0]     up_nxt, dn_nxt, lf_nxt, rt_nxt;
  logic [pgs_pkg::CRD_W-1:0]     row7, col7, row_p1, col_p1, tap_row, tap_col;
  logic [pgs_pkg::ADDR_W-1:0]    wr_addr, tap_addr, ram_addr;
  logic [pgs_pkg::DATA_W-1:0]    rdata;
  logic                          acc_v_r, acc_ctr_r;
  logic [pgs_pkg::ACC_W-1:0]     acc_r, biased, term;
  logic [pgs_pkg::DATA_W-1:0]    result;
  logic                          in_range;
  logic                          out_valid_r;
  pgs_pkg::pgs_out_t             out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_r <= pgs_pkg::clamp_size(pgs_pkg::RST_ROWS, pgs_pkg::MAX_ROWS);
      nc_r <= pgs_pkg::clamp_size(pgs_pkg::RST_COLS, pgs_pkg::MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == pgs_pkg::REG_ROWS) begin
        nr_r <= pgs_pkg::clamp_size(cfg_data, pgs_pkg::MAX_ROWS);
      end else if (cfg_index == pgs_pkg::REG_COLS) begin
        nc_r <= pgs_pkg::clamp_size(cfg_data, pgs_pkg::MAX_COLS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
  end

  assign row7     = pgs_pkg::CRD_W'(item_r.row);
  assign col7     = pgs_pkg::CRD_W'(item_r.col);
  assign row_p1   = row7 + pgs_pkg::CRD_W'(1);
  assign col_p1   = col7 + pgs_pkg::CRD_W'(1);
  assign in_range = (row7 < nr_r) && (col7 < nc_r);

  assign up_nxt = (row7 == '0) ? nr_r - pgs_pkg::CRD_W'(1) : row7 - pgs_pkg::CRD_W'(1);
  assign dn_nxt = (row_p1 >= nr_r) ? '0 : row_p1;
  assign lf_nxt = (col7 == '0) ? nc_r - pgs_pkg::CRD_W'(1) : col7 - pgs_pkg::CRD_W'(1);
  assign rt_nxt = (col_p1 >= nc_r) ? '0 : col_p1;

  always_ff @(posedge clk) begin
    if (cmd.nbr) begin
      up_r <= up_nxt;
      dn_r <= dn_nxt;
      lf_r <= lf_nxt;
      rt_r <= rt_nxt;
    end
  end

  always_comb begin
    tap_row = row7;
    tap_col = col7;
    case (cmd.tap)
      pgs_pkg::TAP_CTR: begin tap_row = row7; tap_col = col7; end
      pgs_pkg::TAP_UP:  begin tap_row = up_r; tap_col = col7; end
      pgs_pkg::TAP_DN:  begin tap_row = dn_r; tap_col = col7; end
      pgs_pkg::TAP_LF:  begin tap_row = row7; tap_col = lf_r; end
      pgs_pkg::TAP_RT:  begin tap_row = row7; tap_col = rt_r; end
      pgs_pkg::TAP_UL:  begin tap_row = up_r; tap_col = lf_r; end
      pgs_pkg::TAP_DL:  begin tap_row = dn_r; tap_col = lf_r; end
      pgs_pkg::TAP_UR:  begin tap_row = up_r; tap_col = rt_r; end
      pgs_pkg::TAP_DR:  begin tap_row = dn_r; tap_col = rt_r; end
      default:          begin tap_row = row7; tap_col = col7; end
    endcase
  end

  assign tap_addr = pgs_pkg::ADDR_W'(tap_row) * pgs_pkg::ADDR_W'(pgs_pkg::MAX_COLS)
                  + pgs_pkg::ADDR_W'(tap_col);
  assign wr_addr  = pgs_pkg::ADDR_W'(row7) * pgs_pkg::ADDR_W'(pgs_pkg::MAX_COLS)
                  + pgs_pkg::ADDR_W'(col7);
  assign ram_addr = cmd.wr ? wr_addr : tap_addr;

  pgs_ram #(
    .WIDTH(pgs_pkg::DATA_W),
    .DEPTH(pgs_pkg::DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (cmd.wr),
    .addr (ram_addr),
    .wdata(item_r.sample),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r   <= 1'b0;
      acc_ctr_r <= 1'b0;
    end else begin
      acc_v_r   <= cmd.rd;
      acc_ctr_r <= cmd.rd && (cmd.tap == pgs_pkg::TAP_CTR);
    end
  end

  // offset binary keeps the sum unsigned; weights add to 16
  assign biased = pgs_pkg::ACC_W'(rdata ^ pgs_pkg::BIAS);
  assign term   = acc_ctr_r ? (biased << pgs_pkg::CTR_SHIFT) : biased;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      acc_r <= '0;
    end else if (acc_v_r) begin
      acc_r <= acc_r + term;
    end
  end

  assign result = acc_r[pgs_pkg::DATA_W+pgs_pkg::DIV_SHIFT-1:pgs_pkg::DIV_SHIFT]
                ^ pgs_pkg::BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.smoothed   <= in_range ? result : '0;
      out_data_r.addr_error <= !in_range;
    end
  end

  assign sts.is_read  = (item_r.func == pgs_pkg::FUNC_RD);
  assign sts.in_range = in_range;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
endmodule
`default_nettype wire

// ----- rtl/periodic_grid_smoothing_core.sv -----
// Top level: periodic 3x3 grid smoothing core
//
// Input channel (in_valid, in_stall, in_data) carries one item: a write
// (func 0) stores sample at (row, col); a read (func 1) asks for the
// weighted 3x3 average there, neighbors wrapping at the sizes in use.
// Result channel (out_valid, out_stall, out_data) gives one item per read,
// none per write; a read outside the sizes in use returns addr_error.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) sets rows in
// use (index 0) and columns in use (index 1); cfg_ready is always high.
// One item is in work at a time. A write passes the decode state, a read
// outside the sizes decode and result, a read in range decode, fetch,
// drain and result: nine cells are fetched one per cycle through the
// single port of the grid memory. The output register lets the next
// item be accepted while a result waits; a stalled receiver holds the
// result and only blocks the next read when that read is ready to load.
// Reset clears control state and sets both sizes to 64; the grid is not
// cleared and must be written before it is read.
`default_nettype none
module periodic_grid_smoothing_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pgs_pkg::pgs_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pgs_pkg::pgs_out_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pgs_pkg::CFG_W-1:0]     cfg_data
);
  pgs_pkg::pgs_cmd_t cmd;
  pgs_pkg::pgs_sts_t sts;

  assign cfg_ready = 1'b1;

  pgs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  pgs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );
endmodule
`default_nettype wire

// ----- rtl/pgs_checker.sv -----
// Checker: port-level properties of the grid smoothing core, with its bind
`default_nettype none
`include "periodic_grid_smoothing_core_defines.svh"
module pgs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire pgs_pkg::pgs_out_t out_data
);
  `PGS_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)
  `PGS_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `PGS_ASSERT_IMP(a_error_zero, out_valid && out_data.addr_error, out_data.smoothed == '0)
  `PGS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

bind periodic_grid_smoothing_core pgs_checker u_pgs_checker (.*);
`default_nettype wire
